FILE: sv/sed_pkg.sv
`timescale 1ns / 1ps
// sed_pkg: request/result types and operation codes for the edit distance block
// no dependencies

package sed_pkg;

    localparam int SYMBOL_W = 32;
    localparam int DIST_W   = 11;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STREAM = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [DIST_W-1:0] DIST_MAX = 11'h7FF;

    typedef struct packed {
        logic [1:0]          operation;
        logic [SYMBOL_W-1:0] symbol;
    } t_request;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              error;
    } t_result;

endpackage

FILE: sv/sed_cell.sv
`timescale 1ns / 1ps
// sed_cell: one column cell of the systolic row, holds a reference symbol and
// one distance entry, passes the wavefront to its right-hand neighbour
// no package dependencies

module sed_cell #(
    parameter int IDX = 1,
    parameter int DW  = 11,
    parameter int SW  = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_clr,
    input  logic          i_load_en,
    input  logic [DW-1:0] i_ref_len,
    input  logic [SW-1:0] i_load_sym,
    input  logic          i_wv,
    input  logic [SW-1:0] i_wsym,
    input  logic [DW-1:0] i_wnew,
    input  logic [DW-1:0] i_wold,
    output logic          o_wv,
    output logic [SW-1:0] o_wsym,
    output logic [DW-1:0] o_wnew,
    output logic [DW-1:0] o_wold
);

    logic          r_active;
    logic [SW-1:0] r_sym;
    logic [DW-1:0] r_d;
    logic          r_wv;
    logic [SW-1:0] r_wsym;
    logic [DW-1:0] r_wnew;
    logic [DW-1:0] r_wold;

    logic [DW:0]   up_c;
    logic [DW:0]   left_c;
    logic [DW:0]   diag_c;
    logic [DW:0]   min_ab;
    logic [DW:0]   min_all;
    logic          load_here;

    assign load_here = i_load_en && (i_ref_len == DW'(IDX - 1));

    always_comb begin
        up_c    = {1'b0, r_d} + (DW+1)'(1);
        left_c  = {1'b0, i_wnew} + (DW+1)'(1);
        diag_c  = {1'b0, i_wold} + (DW+1)'(r_sym != i_wsym);
        min_ab  = (up_c < left_c) ? up_c : left_c;
        min_all = (min_ab < diag_c) ? min_ab : diag_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_active <= 1'b0;
            r_d      <= DW'(IDX);
            r_wv     <= 1'b0;
        end else begin
            r_wv <= i_wv;
            if (load_here) begin
                r_active <= 1'b1;
            end
            if (i_wv && r_active) begin
                r_d <= min_all[DW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_here) begin
            r_sym <= i_load_sym;
        end
        // past the loaded part the column value rides through unchanged
        if (i_wv) begin
            r_wsym <= i_wsym;
            if (r_active) begin
                r_wnew <= min_all[DW-1:0];
                r_wold <= r_d;
            end else begin
                r_wnew <= i_wnew;
                r_wold <= i_wold;
            end
        end
    end

    assign o_wv   = r_wv;
    assign o_wsym = r_wsym;
    assign o_wnew = r_wnew;
    assign o_wold = r_wold;

endmodule

FILE: sv/sequence_edit_distance.sv
`timescale 1ns / 1ps
// sequence_edit_distance: top level, request decode, counters and a row of
// sed_cell instances; uses sed_pkg types and codes
//
//  channel  | ports                    | handshake
//  ---------+--------------------------+-------------------------------------
//  request  | start, i_req, busy       | taken when start is high, busy low
//  result   | o_done, o_res            | one-cycle strobe, cannot be held off
//
// load and stream requests may follow back to back;
// a streamed symbol walks the row of MAX_LEN cells one cell per cycle.
// a finish request holds busy high through the drain state while the last wave
// leaves the row, then o_done pulses and the block is back in reset state.
// reset is synchronous, active low, and clears all cells at once.

module sequence_edit_distance #(
    parameter int MAX_LEN     = 1024,
    parameter int SYMBOL_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  sed_pkg::t_request i_req,
    output logic              busy,
    output logic              o_done,
    output sed_pkg::t_result  o_res
);

    localparam int DW  = $clog2(MAX_LEN + 1);
    localparam int SW  = (SYMBOL_BITS < sed_pkg::SYMBOL_W) ? SYMBOL_BITS : sed_pkg::SYMBOL_W;
    localparam int DWX = (DW > sed_pkg::DIST_W) ? DW : sed_pkg::DIST_W;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state        r_state;
    logic [DW-1:0] r_ref_len;
    logic [DW-1:0] r_str_len;
    logic [DW-1:0] r_cnt;
    logic          r_err;
    logic          r_head_v;
    logic [SW-1:0] r_head_sym;
    logic [DW-1:0] r_head_new;
    logic [DW-1:0] r_head_old;
    logic          r_done;
    sed_pkg::t_result r_res;

    logic          accept;
    logic          do_load;
    logic          do_stream;
    logic          load_bad;
    logic          stream_bad;
    logic          clr;
    logic [DW-1:0] final_d;
    logic [DWX-1:0] final_x;

    logic          w_v    [0:MAX_LEN];
    logic [SW-1:0] w_sym  [0:MAX_LEN];
    logic [DW-1:0] w_new  [0:MAX_LEN];
    logic [DW-1:0] w_old  [0:MAX_LEN];

    assign accept     = start && !busy;
    assign load_bad   = (r_str_len != '0) || (r_ref_len >= DW'(MAX_LEN));
    assign stream_bad = (r_str_len >= DW'(MAX_LEN));
    assign do_load    = accept && (i_req.operation == sed_pkg::OP_LOAD) && !load_bad;
    assign do_stream  = accept && (i_req.operation == sed_pkg::OP_STREAM) && !stream_bad;
    assign clr        = (r_state == ST_DRAIN) && (r_cnt == DW'(1));

    // with nothing streamed the entry at the reference length is still its index
    assign final_d = (r_str_len == '0) ? r_ref_len : w_new[MAX_LEN];
    assign final_x = DWX'(final_d);

    assign w_v[0]   = r_head_v;
    assign w_sym[0] = r_head_sym;
    assign w_new[0] = r_head_new;
    assign w_old[0] = r_head_old;

    for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
        sed_cell #(
            .IDX (g),
            .DW  (DW),
            .SW  (SW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clr      (clr),
            .i_load_en  (do_load),
            .i_ref_len  (r_ref_len),
            .i_load_sym (i_req.symbol[SW-1:0]),
            .i_wv       (w_v[g-1]),
            .i_wsym     (w_sym[g-1]),
            .i_wnew     (w_new[g-1]),
            .i_wold     (w_old[g-1]),
            .o_wv       (w_v[g]),
            .o_wsym     (w_sym[g]),
            .o_wnew     (w_new[g]),
            .o_wold     (w_old[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ref_len <= '0;
            r_str_len <= '0;
            r_cnt     <= '0;
            r_err     <= 1'b0;
            r_head_v  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_head_v <= do_stream;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_req.operation)
                            sed_pkg::OP_LOAD: begin
                                if (load_bad) begin
                                    r_err <= 1'b1;
                                end else begin
                                    r_ref_len <= r_ref_len + DW'(1);
                                end
                            end
                            sed_pkg::OP_STREAM: begin
                                if (stream_bad) begin
                                    r_err <= 1'b1;
                                end else begin
                                    r_str_len <= r_str_len + DW'(1);
                                end
                            end
                            sed_pkg::OP_FINISH: begin
                                r_state <= ST_DRAIN;
                                r_cnt   <= DW'(MAX_LEN);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_DRAIN: begin
                    if (clr) begin
                        r_state   <= ST_IDLE;
                        r_done    <= 1'b1;
                        r_ref_len <= '0;
                        r_str_len <= '0;
                        r_err     <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt - DW'(1);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_stream) begin
            r_head_sym <= i_req.symbol[SW-1:0];
            r_head_new <= r_str_len + DW'(1);
            r_head_old <= r_str_len;
        end
        if (clr) begin
            r_res.error <= r_err;
            if (final_x > DWX'(sed_pkg::DIST_MAX)) begin
                r_res.distance <= sed_pkg::DIST_MAX;
            end else begin
                r_res.distance <= final_x[sed_pkg::DIST_W-1:0];
            end
        end
    end

    assign busy   = (r_state == ST_DRAIN);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
